@@ rtl/core/assert_macros.svh @@
// Assertion helper macros for the WS2812 pulse encoder RTL.
// Included by files that carry concurrent checks; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/core/wsppe_pkg.sv @@
// Shared types, constants and helpers of the WS2812 pixel pulse encoder.
// No dependencies; compiled first.
package wsppe_pkg;

    // Pixel framing
    localparam int BITS_PER_PIXEL    = 24;
    localparam int WORD_IDX_W        = $clog2(BITS_PER_PIXEL + 1);
    localparam int RESET_PERIODS_DEF = 50;

    // Register reset values and brightness limits
    localparam logic [15:0] BIT_PERIOD_RST = 16'd300;
    localparam logic [7:0]  LED_COUNT_RST  = 8'd7;
    localparam logic [8:0]  BRIGHT_FULL    = 9'd256;
    localparam logic [8:0]  BRIGHT_MIN     = 9'd26;

    // Config port layout
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_PERIOD = 2'd0,
        REG_LED_COUNT  = 2'd1,
        REG_BRIGHTNESS = 2'd2
    } reg_index_t;

    // High-time math: floor(p*16/25) = (p*TICK_RECIP) >> 21,
    // floor(p*8/25) = (p*TICK_RECIP) >> 22, exact for 16-bit p.
    localparam int          TICK_RECIP_W = 21;
    localparam logic [TICK_RECIP_W-1:0] TICK_RECIP = 21'd1342178;
    localparam int          TICK_PROD_W  = 16 + TICK_RECIP_W;
    localparam int          ONE_SHIFT    = 21;
    localparam int          ZERO_SHIFT   = 22;

    // Settings seen by the pulse emitter
    typedef struct packed {
        logic [15:0] ticks_one;
        logic [15:0] ticks_zero;
        logic [7:0]  led_count;
        logic [8:0]  brightness;
    } cfg_t;

    // Brightness scaling in Q1.8, truncated
    function automatic logic [7:0] scale_colour(input logic [7:0] c, input logic [8:0] b);
        logic [16:0] p;
        p = 17'(c) * 17'(b);
        return p[15:8];
    endfunction

endpackage

@@ rtl/core/wsppe_if.sv @@
// Channel interfaces of the WS2812 pixel pulse encoder: pixel in, pulse out, config.
// Depends on wsppe_pkg.
interface wsppe_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface wsppe_pulse_if;
    logic        valid;
    logic        ready;
    logic        is_reset_gap;
    logic [15:0] high_ticks;
    logic [5:0]  repeat_periods;
    logic        run_last;

    modport source (output valid, output is_reset_gap, output high_ticks,
                    output repeat_periods, output run_last, input ready);
    modport sink   (input valid, input is_reset_gap, input high_ticks,
                    input repeat_periods, input run_last, output ready);
endinterface

interface wsppe_cfg_if;
    import wsppe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/core/wsppe_cfg_regs.sv @@
// Configuration registers and derived high times of the WS2812 pulse encoder.
// Depends on wsppe_pkg and wsppe_if.
module wsppe_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    wsppe_cfg_if.sink         cfg,
    output wsppe_pkg::cfg_t   cfg_val
);
    import wsppe_pkg::*;

    logic [15:0]            period_reg;
    logic [7:0]             count_reg;
    logic [8:0]             bright_reg;
    logic [TICK_PROD_W-1:0] tick_prod_reg;
    logic [8:0]             bright_wr;
    logic                   wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;
    assign bright_wr = cfg.wdata[8:0];

    // Register file; brightness above full is dropped, under the floor is off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= BIT_PERIOD_RST;
            count_reg  <= LED_COUNT_RST;
            bright_reg <= BRIGHT_FULL;
        end
        else if (wr)
        begin
            unique case (cfg.reg_index)
                REG_BIT_PERIOD: period_reg <= cfg.wdata;
                REG_LED_COUNT:  count_reg  <= cfg.wdata[7:0];
                REG_BRIGHTNESS:
                begin
                    if (bright_wr <= BRIGHT_FULL)
                    begin
                        bright_reg <= (bright_wr < BRIGHT_MIN) ? 9'd0 : bright_wr;
                    end
                end
                default: ;
            endcase
        end
    end

    // Reciprocal product for the one and zero high times
    always_ff @(posedge clk)
    begin
        tick_prod_reg <= TICK_PROD_W'(period_reg) * TICK_PROD_W'(TICK_RECIP);
    end

    assign cfg_val.ticks_one  = tick_prod_reg[ONE_SHIFT+15:ONE_SHIFT];
    assign cfg_val.ticks_zero = 16'(tick_prod_reg[TICK_PROD_W-1:ZERO_SHIFT]);
    assign cfg_val.led_count  = count_reg;
    assign cfg_val.brightness = bright_reg;

endmodule

@@ rtl/core/wsppe_emitter.sv @@
// Pixel input stage and serial pulse word emitter of the WS2812 encoder.
// Depends on wsppe_pkg, wsppe_if and assert_macros.svh.
`include "assert_macros.svh"
module wsppe_emitter #(
    parameter int RESET_PERIODS = wsppe_pkg::RESET_PERIODS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wsppe_pkg::cfg_t   cfg_val,
    wsppe_pixel_if.sink       pix,
    wsppe_pulse_if.source     pulse
);
    import wsppe_pkg::*;

    logic                      in_valid_reg;
    logic [7:0]                red_reg;
    logic [7:0]                green_reg;
    logic [7:0]                blue_reg;
    logic                      busy_reg;
    logic [BITS_PER_PIXEL-1:0] bits_reg;
    logic [WORD_IDX_W-1:0]     word_idx_reg;
    logic                      gap_reg;
    logic [7:0]                pos_reg;

    logic                      take;
    logic                      word_is_gap;
    logic                      last_word;
    logic                      load;
    logic [7:0]                pos_next;
    logic                      gap_next;

    // Handshake and word position decode
    assign take        = busy_reg & pulse.ready;
    assign word_is_gap = (word_idx_reg == WORD_IDX_W'(BITS_PER_PIXEL));
    assign last_word   = word_is_gap ||
                         ((word_idx_reg == WORD_IDX_W'(BITS_PER_PIXEL - 1)) && !gap_reg);
    assign load        = in_valid_reg && (!busy_reg || (take && last_word));
    assign pix.ready   = !in_valid_reg || load;

    // Frame position: gap when the count wraps or reaches led_count
    assign pos_next = pos_reg + 8'd1;
    assign gap_next = (pos_next == 8'd0) || (pos_next >= cfg_val.led_count);

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pix.ready)
        begin
            in_valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid && pix.ready)
        begin
            red_reg   <= pix.red;
            green_reg <= pix.green;
            blue_reg  <= pix.blue;
        end
    end

    // Emitter control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            word_idx_reg <= '0;
            gap_reg      <= 1'b0;
            pos_reg      <= '0;
        end
        else if (load)
        begin
            busy_reg     <= 1'b1;
            word_idx_reg <= '0;
            gap_reg      <= gap_next;
            pos_reg      <= gap_next ? 8'd0 : pos_next;
        end
        else if (take)
        begin
            if (last_word)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                word_idx_reg <= word_idx_reg + WORD_IDX_W'(1);
            end
        end
    end

    // Scaled colour bits, green red blue, MSB first
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bits_reg <= {scale_colour(green_reg, cfg_val.brightness),
                         scale_colour(red_reg,   cfg_val.brightness),
                         scale_colour(blue_reg,  cfg_val.brightness)};
        end
        else if (take)
        begin
            bits_reg <= bits_reg << 1;
        end
    end

    // Output word
    assign pulse.valid          = busy_reg;
    assign pulse.is_reset_gap   = word_is_gap;
    assign pulse.high_ticks     = word_is_gap ? 16'd0 :
                                  (bits_reg[BITS_PER_PIXEL-1] ? cfg_val.ticks_one
                                                              : cfg_val.ticks_zero);
    assign pulse.repeat_periods = word_is_gap ? 6'(RESET_PERIODS) : 6'd1;
    assign pulse.run_last       = last_word;

    // Checks
    `ASSERT_CLK(a_idx_range, clk, rst_n, busy_reg |-> (word_idx_reg <= WORD_IDX_W'(BITS_PER_PIXEL)))
    `ASSERT_CLK(a_gap_word_only_on_gap, clk, rst_n, (busy_reg && word_is_gap) |-> gap_reg)
    `ASSERT_CLK(a_idle_after_last, clk, rst_n, (take && last_word && !load) |=> !busy_reg)
    `ASSERT_CLK(a_pixel_held, clk, rst_n, (in_valid_reg && !load) |=> (in_valid_reg && $stable(red_reg)))

endmodule

@@ rtl/core/ws2812_pixel_pulse_encoder.sv @@
// WS2812 pixel pulse encoder, top level.
// Depends on wsppe_pkg, wsppe_if, wsppe_cfg_regs and wsppe_emitter.
//
// pix (sink): one RGB pixel word per handshake, in strip order.
// pulse (source): PWM words, 24 per pixel (green, red, blue, MSB first), each
//   with the high time for its bit; after led_count pixels a 25th reset-gap
//   word follows. run_last marks the final word of each pixel.
// cfg (sink): register writes, always ready; index 0 bit period, 1 led count,
//   2 brightness. Write only while the block is idle.
// With the emitter idle, a taken pixel passes through the input register into
//   the emitter's shift register, and its first word goes valid once loaded.
// Throughput: one word per cycle while pulse.ready is high, set by the single
//   serial word emitter. One further pixel waits in the input register while
//   the current one is emitted, so pixels flow back to back.
// Stall: while pulse.ready is low the current word holds; once the input
//   register is full and the emitter cannot load it, pix.ready drops.
// Reset: channels empty, pixel count cleared, registers at 300 / 7 / 256.
module ws2812_pixel_pulse_encoder #(
    parameter int RESET_PERIODS = wsppe_pkg::RESET_PERIODS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    wsppe_pixel_if.sink   pix,
    wsppe_pulse_if.source pulse,
    wsppe_cfg_if.sink     cfg
);
    import wsppe_pkg::*;

    cfg_t cfg_val;

    // Register file and high-time math
    wsppe_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    // Pixel stage and word emitter
    wsppe_emitter #(
        .RESET_PERIODS (RESET_PERIODS)
    ) u_emitter (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_val (cfg_val),
        .pix     (pix),
        .pulse   (pulse)
    );

endmodule
